### sv/gst3_pkg.sv
`default_nettype none

package gst3_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int LARGEST_W = 32;
  localparam int TOTAL_W   = 34;

  localparam logic [LARGEST_W-1:0] LARGEST_MAX = 32'hFFFF_FFFF;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = 34'h3_FFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;

  // work handed from the byte front end to the group back end
  typedef struct packed {
    logic add;    // add value into the group sum first
    logic close;  // then close the group into the top set
    logic last;   // then report and restart
  } ev_flags_t;

endpackage

`default_nettype wire

### sv/gst3_front.sv
`default_nettype none

module gst3_front #(
  parameter int SUM_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            char_byte,
  input  wire logic                  end_of_input,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  q_full,
  output logic                       q_push,
  output gst3_pkg::ev_flags_t        ev_flags,
  output logic [SUM_WIDTH-1:0]       ev_value
);

  localparam int WW = SUM_WIDTH + 4;

  logic [SUM_WIDTH-1:0] num;
  logic                 at_line_start;

  logic                 accept;
  logic                 is_digit;
  logic                 is_nl;
  logic [WW-1:0]        wide;
  logic [SUM_WIDTH-1:0] num_dig;
  logic [SUM_WIDTH-1:0] num_now;
  logic                 start_after;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_digit = (char_byte inside {[gst3_pkg::CHAR_ZERO:gst3_pkg::CHAR_NINE]});
    is_nl    = (char_byte == gst3_pkg::CHAR_NEWLINE);
    // num*10 + digit as shifts; any carry into the top nibble saturates
    wide     = (WW'(num) << 3) + (WW'(num) << 1) + WW'(char_byte[3:0]);
    num_dig  = (|wide[WW-1:SUM_WIDTH]) ? '1 : wide[SUM_WIDTH-1:0];
    num_now  = is_digit ? num_dig : num;
    if (is_digit) begin
      start_after = 1'b0;
    end else if (is_nl) begin
      start_after = 1'b1;
    end else begin
      start_after = at_line_start;
    end
    ev_flags.add   = (is_nl && !at_line_start) || (end_of_input && !start_after);
    ev_flags.close = (is_nl && at_line_start) || end_of_input;
    ev_flags.last  = end_of_input;
    ev_value       = num_now;
    q_push         = accept && (ev_flags.add || ev_flags.close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num           <= '0;
      at_line_start <= 1'b1;
    end else if (accept) begin
      if (end_of_input) begin
        num           <= '0;
        at_line_start <= 1'b1;
      end else if (is_digit) begin
        num           <= num_dig;
        at_line_start <= 1'b0;
      end else if (is_nl) begin
        num           <= '0;
        at_line_start <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/gst3_queue.sv
`default_nettype none

module gst3_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/gst3_back.sv
`default_nettype none

module gst3_back #(
  parameter int SUM_WIDTH = 32,
  parameter int TOP_COUNT = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire gst3_pkg::ev_flags_t          q_flags,
  input  wire logic [SUM_WIDTH-1:0]         q_value,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gst3_pkg::LARGEST_W-1:0]    largest_group_sum,
  output logic [gst3_pkg::TOTAL_W-1:0]      top_three_total
);

  localparam int TW = SUM_WIDTH + $clog2(TOP_COUNT) + 1;
  localparam int SW = (TW > gst3_pkg::TOTAL_W + 1) ? TW : gst3_pkg::TOTAL_W + 1;
  localparam int LW = (SUM_WIDTH > gst3_pkg::LARGEST_W + 1) ? SUM_WIDTH
                                                             : gst3_pkg::LARGEST_W + 1;

  logic [SUM_WIDTH-1:0] grp;
  logic [SUM_WIDTH-1:0] top  [TOP_COUNT];
  logic [SUM_WIDTH-1:0] ins  [TOP_COUNT];
  logic [SUM_WIDTH-1:0] snap [TOP_COUNT];
  logic                 snap_valid;
  logic                 snap_move;

  logic [SUM_WIDTH:0]   grp_sum;
  logic [SUM_WIDTH-1:0] grp_new;
  logic [TOP_COUNT-1:0] above;
  logic [SW-1:0]        total;
  logic [LW-1:0]        big;

  always_comb begin
    grp_sum = {1'b0, grp} + {1'b0, q_value};
    if (q_flags.add) begin
      grp_new = grp_sum[SUM_WIDTH] ? '1 : grp_sum[SUM_WIDTH-1:0];
    end else begin
      grp_new = grp;
    end
    // set is descending, so "above" is a run of zeros then ones; ties keep their place
    for (int i = 0; i < TOP_COUNT; i++) begin
      above[i] = (top[i] < grp_new);
    end
    for (int i = 0; i < TOP_COUNT; i++) begin
      if (!above[i]) begin
        ins[i] = top[i];
      end else if (i == 0) begin
        ins[i] = grp_new;
      end else if (!above[i-1]) begin
        ins[i] = grp_new;
      end else begin
        ins[i] = top[i-1];
      end
    end
  end

  assign snap_move = snap_valid && (!out_valid || out_ready);
  assign q_pop     = q_valid && (!q_flags.last || !snap_valid || snap_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
      for (int i = 0; i < TOP_COUNT; i++) begin
        top[i] <= '0;
      end
    end else if (q_pop) begin
      if (q_flags.close) begin
        grp <= '0;
        for (int i = 0; i < TOP_COUNT; i++) begin
          top[i] <= q_flags.last ? '0 : ins[i];
        end
      end else begin
        grp <= grp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_flags.last) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        snap[i] <= ins[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (q_pop && q_flags.last) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  // result stage: clip largest, add up the kept sums
  always_comb begin
    total = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      total = total + SW'(snap[i]);
    end
    big = LW'(snap[0]);
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      largest_group_sum <= (big > LW'(gst3_pkg::LARGEST_MAX)) ? gst3_pkg::LARGEST_MAX
                                                              : big[gst3_pkg::LARGEST_W-1:0];
      top_three_total   <= (total > SW'(gst3_pkg::TOTAL_MAX)) ? gst3_pkg::TOTAL_MAX
                                                              : total[gst3_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/group_sum_top3_tracker_core.sv
// channel  | dir | handshake             | beat
// ---------+-----+-----------------------+-------------------------------------
// in       | in  | in_valid / in_ready   | char_byte, end_of_input
// out      | out | out_valid / out_ready | largest_group_sum, top_three_total
//
// One byte per cycle while the queue has room: the front builds the number as
// bytes arrive and posts group work into a 4-beat queue; the back retires one
// queue entry a cycle unless a last-flagged head waits on a held snapshot. With
// no stalls the last byte goes via queue write, snapshot pop, output reg to out_valid.
// Reset is synchronous; group and top-set sums clear and no beat is pending afterwards.
// in_ready drops only when the queue is full, i.e. out_ready held low with a
// result waiting, another in the snapshot and a last-flagged beat at the queue head.
`default_nettype none

module group_sum_top3_tracker_core #(
  parameter int TOP_COUNT = 3,
  parameter int SUM_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [7:0]                   char_byte,
  input  wire logic                         end_of_input,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  output logic [gst3_pkg::LARGEST_W-1:0]    largest_group_sum,
  output logic [gst3_pkg::TOTAL_W-1:0]      top_three_total,
  output logic                              out_valid,
  input  wire logic                         out_ready
);

  localparam int FW = $bits(gst3_pkg::ev_flags_t);
  localparam int QW = FW + SUM_WIDTH;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  gst3_pkg::ev_flags_t  ev_flags;
  logic [SUM_WIDTH-1:0] ev_value;
  logic [QW-1:0]        q_rdata;
  gst3_pkg::ev_flags_t  hd_flags;
  logic [SUM_WIDTH-1:0] hd_value;

  gst3_front #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .char_byte(char_byte),
    .end_of_input(end_of_input),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .q_full(q_full),
    .q_push(q_push),
    .ev_flags(ev_flags),
    .ev_value(ev_value)
  );

  gst3_queue #(
    .WIDTH(QW),
    .DEPTH(gst3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata({ev_flags, ev_value}),
    .pop(q_pop),
    .rdata(q_rdata),
    .full(q_full),
    .empty(q_empty)
  );

  assign hd_flags = q_rdata[QW-1:SUM_WIDTH];
  assign hd_value = q_rdata[SUM_WIDTH-1:0];

  gst3_back #(
    .SUM_WIDTH(SUM_WIDTH),
    .TOP_COUNT(TOP_COUNT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(!q_empty),
    .q_flags(hd_flags),
    .q_value(hd_value),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .largest_group_sum(largest_group_sum),
    .top_three_total(top_three_total)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_last_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_input) |=> !q_empty)
    else $error("last beat produced no queued work");
`endif

endmodule

`default_nettype wire
